>>> src/pdc_pkg.sv
// Shared constants and types for the pairwise discordance counter.
`default_nettype none
package pdc_pkg;

	// Number of items a group can hold; one cell in the chain per item.
	localparam int MAX_ITEMS = 64;
	localparam int IDX_W     = (MAX_ITEMS > 2) ? $clog2(MAX_ITEMS) : 1;
	localparam int COUNT_W   = 11;
	localparam int SUM_W     = COUNT_W + 1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef struct packed {
		logic signed [31:0] score;
		logic        [15:0] rating;
		logic               last;
	} pdc_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] error_pairs;
		logic [COUNT_W-1:0] total_pairs;
		logic               group_too_long;
	} pdc_result_t;

	// Token that travels along the chain, one cell per cycle while the chain advances.
	typedef struct packed {
		logic             vld;
		pdc_item_t        item;
		logic             kept;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] errs;
	} pdc_tok_t;

endpackage
`default_nettype wire

>>> src/pdc_cell.sv
// One cell of the chain: holds one stored item and compares passing items with it.
`default_nettype none
module pdc_cell
	import pdc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic [IDX_W-1:0] cell_idx,
	input  wire pdc_tok_t         tok_in,
	output pdc_tok_t              tok_out
);

	logic               vld_q;
	logic signed [31:0] score_q;
	logic        [15:0] rating_q;
	logic               store;
	logic               cmp;
	logic               disc;
	pdc_tok_t           tok_nxt;
	pdc_tok_t           tok_q;

	always_comb begin
		store = tok_in.vld && !tok_in.kept && !vld_q;
		cmp   = tok_in.vld && !tok_in.kept && vld_q;
		disc  = ((score_q >= tok_in.item.score) && (rating_q < tok_in.item.rating)) ||
			((score_q <= tok_in.item.score) && (rating_q > tok_in.item.rating));
		tok_nxt = tok_in;
		if (store) begin
			tok_nxt.kept = 1'b1;
			tok_nxt.idx  = cell_idx;
		end
		if (cmp && disc) begin
			tok_nxt.errs = tok_in.errs + IDX_W'(1);
		end
	end

	// The last item of a group empties every cell as it passes, so the next
	// group, coming behind it, finds the chain clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			tok_q <= '0;
		end else if (adv) begin
			tok_q <= tok_nxt;
			if (tok_in.vld && tok_in.item.last) begin
				vld_q <= 1'b0;
			end else if (store) begin
				vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && store) begin
			score_q  <= tok_in.item.score;
			rating_q <= tok_in.item.rating;
		end
	end

	assign tok_out = tok_q;

endmodule
`default_nettype wire

>>> src/pdc_tally.sv
// End of the chain: sums per-item counts for the group and holds the result.
`default_nettype none
module pdc_tally
	import pdc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     adv,
	input  wire pdc_tok_t tok,
	output logic          result_valid,
	output pdc_result_t   result
);

	logic [COUNT_W-1:0] err_q;
	logic [COUNT_W-1:0] tot_q;
	logic               ovf_q;
	logic               res_vld_q;
	pdc_result_t        res_q;
	logic               kept;
	logic [SUM_W-1:0]   err_sum;
	logic [SUM_W-1:0]   tot_sum;
	logic [COUNT_W-1:0] err_new;
	logic [COUNT_W-1:0] tot_new;
	logic               ovf_new;

	always_comb begin
		kept    = tok.vld && tok.kept;
		err_sum = SUM_W'(err_q) + (kept ? SUM_W'(tok.errs) : '0);
		tot_sum = SUM_W'(tot_q) + (kept ? SUM_W'(tok.idx) : '0);
		err_new = err_sum[COUNT_W] ? COUNT_MAX : err_sum[COUNT_W-1:0];
		tot_new = tot_sum[COUNT_W] ? COUNT_MAX : tot_sum[COUNT_W-1:0];
		ovf_new = ovf_q || (tok.vld && !tok.kept);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q     <= '0;
			tot_q     <= '0;
			ovf_q     <= 1'b0;
			res_vld_q <= 1'b0;
		end else if (adv) begin
			res_vld_q <= tok.vld && tok.item.last;
			if (tok.vld) begin
				if (tok.item.last) begin
					err_q <= '0;
					tot_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					err_q <= err_new;
					tot_q <= tot_new;
					ovf_q <= ovf_new;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tok.vld && tok.item.last) begin
			res_q.error_pairs    <= err_new;
			res_q.total_pairs    <= tot_new;
			res_q.group_too_long <= ovf_new;
		end
	end

	assign result_valid = res_vld_q;
	assign result       = res_q;

endmodule
`default_nettype wire

>>> src/pairwise_discordance_counter_core.sv
// Top level: chain of compare cells feeding the group tally.
//
//   channel   valid          stall          payload
//   -------   ------------   ------------   ---------------------
//   items     item_valid     item_stall     item   (pdc_item_t)
//   results   result_valid   result_stall   result (pdc_result_t)
//
// One item is accepted per cycle while item_stall is low. Each item walks the
// chain of MAX_ITEMS cells, one cell per cycle while the chain advances, and
// the tally registers the group's result when the last item of the group
// leaves the chain. Reset clears every cell and the tally. A result held against
// result_stall freezes the whole chain, so item_stall rises in the same cycle.
`default_nettype none
module pairwise_discordance_counter_core
	import pdc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire pdc_item_t   item,
	output logic             result_valid,
	input  wire logic        result_stall,
	output pdc_result_t      result
);

	logic     adv;
	pdc_tok_t tok_chain [0:MAX_ITEMS];

	assign adv        = !result_valid || !result_stall;
	assign item_stall = !adv;

	always_comb begin
		tok_chain[0]      = '0;
		tok_chain[0].vld  = item_valid;
		tok_chain[0].item = item;
	end

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		pdc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.cell_idx (IDX_W'(i)),
			.tok_in   (tok_chain[i]),
			.tok_out  (tok_chain[i+1])
		);
	end

	pdc_tally u_tally (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.tok          (tok_chain[MAX_ITEMS]),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the pairwise discordance counter core.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
	import pdc_pkg::*;

	localparam int ITEM_TARGET  = 800;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int IDLE_PERCENT = 34;

	typedef enum int {
		GRP_SHORT,
		GRP_MEDIUM,
		GRP_FULL,
		GRP_OVERLONG,
		GRP_ALL_DISCORDANT
	} group_kind_t;

	// Tracks the group in flight and holds the results it should produce.
	class discordance_checker;
		logic signed [31:0] held_score [MAX_ITEMS];
		logic [15:0]        held_rating [MAX_ITEMS];
		int                 kept;
		int                 tally;
		bit                 dropped;
		pdc_result_t        expected_counts [$];
		int                 mismatches;

		function new();
			kept = 0;
			tally = 0;
			dropped = 0;
			mismatches = 0;
		endfunction

		function void note_item(pdc_item_t it);
			int errs;
			int total;
			pdc_result_t res;
			errs = 0;
			if (kept < MAX_ITEMS) begin
				for (int i = 0; i < kept; i++) begin
					if ((held_score[i] >= it.score && held_rating[i] < it.rating) ||
					    (held_score[i] <= it.score && held_rating[i] > it.rating))
						errs++;
				end
				tally = tally + errs;
				if (tally > int'(COUNT_MAX))
					tally = int'(COUNT_MAX);
				held_score[kept] = it.score;
				held_rating[kept] = it.rating;
				kept++;
			end else begin
				dropped = 1'b1;
			end
			if (it.last) begin
				total = kept * (kept - 1) / 2;
				if (total > int'(COUNT_MAX))
					total = int'(COUNT_MAX);
				res.error_pairs = tally[COUNT_W-1:0];
				res.total_pairs = total[COUNT_W-1:0];
				res.group_too_long = dropped;
				expected_counts = {expected_counts, res};
				kept = 0;
				tally = 0;
				dropped = 0;
			end
		endfunction

		function void check_result(pdc_result_t got);
			pdc_result_t want;
			if (expected_counts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: err=%0d tot=%0d long=%0d",
						got.error_pairs, got.total_pairs, got.group_too_long);
				return;
			end
			want = expected_counts.pop_front();
			if (got.error_pairs !== want.error_pairs ||
			    got.total_pairs !== want.total_pairs ||
			    got.group_too_long !== want.group_too_long) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: expected err=%0d tot=%0d long=%0d",
						want.error_pairs, want.total_pairs, want.group_too_long);
					$display("          got      err=%0d tot=%0d long=%0d",
						got.error_pairs, got.total_pairs, got.group_too_long);
				end
			end
		endfunction

		function int pending();
			return expected_counts.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	pdc_item_t   item = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	pdc_result_t result;

	discordance_checker sb = new();
	bit idle_on = 1'b1;
	int cycles = 0;
	int items_sent = 0;

	pairwise_discordance_counter_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Both channels are observed here, inputs first, so that a prediction is
	// always in place before its result can be checked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				sb.note_item(item);
			if (result_valid && !result_stall)
				sb.check_result(result);
		end
	end

	always @(posedge clk) begin
		result_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PERCENT);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_item(input pdc_item_t it);
		bit lowered;
		lowered = 1'b0;
		while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
			if (!lowered) begin
				item_valid <= 1'b0;
				lowered = 1'b1;
			end
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send(input logic [31:0] s, input logic [15:0] r, input logic lst);
		pdc_item_t it;
		it.score = s;
		it.rating = r;
		it.last = lst;
		send_item(it);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_score(input bit wide);
		logic [31:0] v;
		if (wide)
			return $urandom();
		case ($urandom_range(0, 5))
			0: v = 32'h8000_0000;
			1: v = 32'h7FFF_FFFF;
			2: v = 32'hFFFF_FFFF;
			default: v = $urandom_range(0, 3) << 16;
		endcase
		return v;
	endfunction

	function automatic logic [15:0] pick_rating(input bit wide);
		if (wide)
			return 16'($urandom_range(0, 65535));
		case ($urandom_range(0, 4))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(1, 3) << 8);
		endcase
	endfunction

	task automatic send_group(input group_kind_t kind);
		int len;
		bit wide_s;
		bit wide_r;
		pdc_item_t it;
		case (kind)
			GRP_SHORT:          len = $urandom_range(1, 8);
			GRP_MEDIUM:         len = $urandom_range(9, 30);
			GRP_FULL:           len = MAX_ITEMS;
			GRP_OVERLONG:       len = MAX_ITEMS + $urandom_range(1, 6);
			default:            len = MAX_ITEMS;
		endcase
		// Narrow value pools give plenty of ties, which exercise both comparisons.
		wide_s = $urandom_range(0, 2) == 0;
		wide_r = $urandom_range(0, 2) == 0;
		for (int i = 0; i < len; i++) begin
			if (kind == GRP_ALL_DISCORDANT) begin
				it.score = -32'sd100000 + i * 3000;
				it.rating = 16'(32'hFFFF - i * 1000);
			end else begin
				it.score = pick_score(wide_s);
				it.rating = pick_rating(wide_r);
			end
			it.last = (i == len - 1);
			send_item(it);
		end
	endtask

	initial begin
		int pick;
		group_kind_t kind;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single item groups at the score and rating extremes.
		send(32'h8000_0000, 16'hFFFF, 1'b1);
		send(32'h7FFF_FFFF, 16'h0000, 1'b1);
		// Equal scores with rising, then falling ratings: one error each.
		send(32'h0000_0005, 16'd100, 1'b0);
		send(32'h0000_0005, 16'd200, 1'b1);
		send(32'h0000_0005, 16'd200, 1'b0);
		send(32'h0000_0005, 16'd100, 1'b1);
		// Equal ratings never count, nor do fully equal items.
		send(32'h0001_0000, 16'h0300, 1'b0);
		send(32'hFFFF_0000, 16'h0300, 1'b1);
		send(32'h0000_1234, 16'h0055, 1'b0);
		send(32'h0000_1234, 16'h0055, 1'b1);
		// Opposite score extremes, discordant both ways round.
		send(32'h7FFF_FFFF, 16'h0000, 1'b0);
		send(32'h8000_0000, 16'hFFFF, 1'b1);
		send(32'h8000_0000, 16'hFFFF, 1'b0);
		send(32'h7FFF_FFFF, 16'h0000, 1'b1);
		// Concordant pair, then a triple in which every pair is discordant.
		send(32'h0000_0001, 16'h0001, 1'b0);
		send(32'h0000_0002, 16'h0002, 1'b1);
		send(32'h0000_0000, 16'h0100, 1'b0);
		send(32'h0001_0000, 16'h0080, 1'b0);
		send(32'hFFFF_FFFF, 16'h0200, 1'b1);

		// Hold the sender back until every result so far has come out.
		drain();

		while (items_sent < ITEM_TARGET) begin
			idle_on = !(items_sent >= 250 && items_sent < 450);
			pick = $urandom_range(0, 99);
			if (pick < 60)
				kind = GRP_SHORT;
			else if (pick < 90)
				kind = GRP_MEDIUM;
			else if (pick < 94)
				kind = GRP_FULL;
			else if (pick < 98)
				kind = GRP_OVERLONG;
			else
				kind = GRP_ALL_DISCORDANT;
			send_group(kind);
		end
		// Make sure both corner groups, all discordant and overlong, appear in every run.
		send_group(GRP_ALL_DISCORDANT);
		send_group(GRP_OVERLONG);

		drain();
		repeat (MAX_ITEMS + 20) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

>>> filelist.f
src/pdc_pkg.sv
src/pdc_cell.sv
src/pdc_tally.sv
src/pairwise_discordance_counter_core.sv
test/tb_top.sv
